>>> design/cwc_pkg.sv
`timescale 1ns / 1ps
// cwc_pkg: shared types and constants for the congestion window controller
// depends on nothing; imported by every module of the block

package cwc_pkg;

  localparam int WIN_W  = 11;
  localparam int RTT_W  = 16;
  localparam int PKT_W  = 32;
  localparam int TIME_W = 32;
  localparam int DUP_W  = 4;
  localparam int CRASH_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [DUP_W-1:0] DUP_MAX = 4'd15;
  localparam logic [WIN_W-1:0] THR_FLOOR = 11'd2;
  localparam logic [RTT_W-1:0] RTT_MAX = 16'hFFFF;

  // request commands
  typedef enum logic [1:0] {
    CMD_ACK     = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_SENT    = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_THR   = 3'd0,
    CFG_INIT_WIN   = 3'd1,
    CFG_INIT_RTT   = 3'd2,
    CFG_DUP_LIMIT  = 3'd3,
    CFG_ACK_TO     = 3'd4,
    CFG_CRASH_TO   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PKT_W-1:0]  packet_number;
    logic [TIME_W-1:0] now_ms;
    logic              sample_this_send;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0] congestion_window;
    logic [WIN_W-1:0] slow_threshold;
    logic             in_avoidance;
    logic [RTT_W-1:0] rtt_estimate_ms;
    logic [PKT_W-1:0] highest_acked;
    logic [PKT_W-1:0] highest_sent;
    logic             rewind;
    logic             peer_crashed;
  } result_t;

endpackage

>>> design/cwc_in_stage.sv
`timescale 1ns / 1ps
// cwc_in_stage: input register for requests
// depends on cwc_pkg

module cwc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cwc_pkg::item_t in_item,
  output logic          item_valid,
  output cwc_pkg::item_t item,
  input  logic          item_take
);
  import cwc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> design/cwc_update.sv
`timescale 1ns / 1ps
// cwc_update: connection state, configuration registers and the per-request update
// depends on cwc_pkg

module cwc_update #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            fire,
  input  cwc_pkg::item_t                  item,
  output cwc_pkg::result_t                res
);
  import cwc_pkg::*;

  localparam int CAP_INT = (WINDOW_MAX < 2047) ? WINDOW_MAX : 2047;
  localparam logic [WIN_W:0] CAP = (WIN_W+1)'(CAP_INT);

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W:0] w);
    logic [WIN_W-1:0] r;
    begin
      if (w == '0) begin
        r = WIN_W'(1);
      end else if (w > CAP) begin
        r = CAP[WIN_W-1:0];
      end else begin
        r = w[WIN_W-1:0];
      end
      return r;
    end
  endfunction

  // configuration
  logic [WIN_W-1:0]   init_thr_r, init_thr_nxt;
  logic [WIN_W-1:0]   init_win_r, init_win_nxt;
  logic [RTT_W-1:0]   init_rtt_r, init_rtt_nxt;
  logic [DUP_W-1:0]   dup_lim_r, dup_lim_nxt;
  logic [RTT_W-1:0]   ack_to_r, ack_to_nxt;
  logic [CRASH_W-1:0] crash_to_r, crash_to_nxt;

  // connection state
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [WIN_W-1:0]  thr_r, thr_nxt;
  logic              mode_r, mode_nxt;
  logic [RTT_W-1:0]  rtt_r, rtt_nxt;
  logic              smp_pend_r, smp_pend_nxt;
  logic [PKT_W-1:0]  smp_num_r, smp_num_nxt;
  logic [TIME_W-1:0] smp_start_r, smp_start_nxt;
  logic [PKT_W-1:0]  acked_r, acked_nxt;
  logic [PKT_W-1:0]  sent_r, sent_nxt;
  logic [DUP_W-1:0]  dup_r, dup_nxt;
  logic [TIME_W-1:0] ack_time_r, ack_time_nxt;
  logic [TIME_W-1:0] send_time_r, send_time_nxt;
  logic [TIME_W-1:0] grow_time_r, grow_time_nxt;

  logic [TIME_W-1:0] sample_gap, growth_gap, quiet, send_quiet;
  logic [TIME_W:0]   rtt_sum;
  logic [TIME_W-1:0] rtt_mean;
  logic [WIN_W-2:0]  half;
  logic [WIN_W-1:0]  shr_thr, shr_win, win_inc;
  logic              shr_mode;
  logic [DUP_W-1:0]  dup_inc;
  logic              rewind, crashed;

  always_comb begin
    init_thr_nxt  = init_thr_r;
    init_win_nxt  = init_win_r;
    init_rtt_nxt  = init_rtt_r;
    dup_lim_nxt   = dup_lim_r;
    ack_to_nxt    = ack_to_r;
    crash_to_nxt  = crash_to_r;
    win_nxt       = win_r;
    thr_nxt       = thr_r;
    mode_nxt      = mode_r;
    rtt_nxt       = rtt_r;
    smp_pend_nxt  = smp_pend_r;
    smp_num_nxt   = smp_num_r;
    smp_start_nxt = smp_start_r;
    acked_nxt     = acked_r;
    sent_nxt      = sent_r;
    dup_nxt       = dup_r;
    ack_time_nxt  = ack_time_r;
    send_time_nxt = send_time_r;
    grow_time_nxt = grow_time_r;
    rewind        = 1'b0;
    crashed       = 1'b0;

    sample_gap = item.now_ms - smp_start_r;
    growth_gap = item.now_ms - grow_time_r;
    quiet      = item.now_ms - ack_time_r;
    send_quiet = item.now_ms - send_time_r;
    rtt_sum    = (TIME_W+1)'(rtt_r) + (TIME_W+1)'(sample_gap);
    rtt_mean   = rtt_sum[TIME_W:1];

    // loss response shared by duplicate acks and ack timeout
    half     = win_r[WIN_W-1:1];
    shr_thr  = ({1'b0, half} > THR_FLOOR) ? {1'b0, half} : THR_FLOOR;
    shr_win  = mode_r ? clamp_win({1'b0, init_win_r}) : win_r;
    shr_mode = (shr_win >= shr_thr);

    win_inc = clamp_win({1'b0, win_r} + (WIN_W+1)'(1));
    dup_inc = (dup_r < DUP_MAX) ? dup_r + DUP_W'(1) : dup_r;

    case (item.cmd)
      CMD_ACK: begin
        if (smp_pend_r && (smp_num_r == item.packet_number)) begin
          rtt_nxt      = (rtt_mean > TIME_W'(RTT_MAX)) ? RTT_MAX : rtt_mean[RTT_W-1:0];
          smp_pend_nxt = 1'b0;
        end
        if ((item.packet_number >= acked_r) && (item.packet_number <= sent_r)) begin
          if (item.packet_number == acked_r) begin
            dup_nxt = dup_inc;
            if (dup_inc >= dup_lim_r) begin
              dup_nxt  = '0;
              thr_nxt  = shr_thr;
              win_nxt  = shr_win;
              mode_nxt = shr_mode;
              sent_nxt = acked_r;
              rewind   = 1'b1;
            end
          end else begin
            dup_nxt   = DUP_W'(1);
            acked_nxt = item.packet_number;
            if (!mode_r) begin
              win_nxt  = win_inc;
              mode_nxt = (win_inc >= thr_r);
            end else if (growth_gap > TIME_W'(rtt_nxt)) begin
              // avoidance grows at most once per round trip
              win_nxt       = win_inc;
              grow_time_nxt = item.now_ms;
            end
          end
          ack_time_nxt = item.now_ms;
        end
      end
      CMD_TIMEOUT: begin
        if (quiet > TIME_W'(crash_to_r)) begin
          crashed = 1'b1;
        end else if ((quiet > TIME_W'(ack_to_r)) && (send_quiet > TIME_W'(ack_to_r))) begin
          thr_nxt  = shr_thr;
          win_nxt  = shr_win;
          mode_nxt = shr_mode;
          sent_nxt = acked_r;
          rewind   = 1'b1;
        end
      end
      CMD_SENT: begin
        sent_nxt      = item.packet_number;
        send_time_nxt = item.now_ms;
        if (item.sample_this_send) begin
          smp_pend_nxt  = 1'b1;
          smp_num_nxt   = item.packet_number;
          smp_start_nxt = item.now_ms;
        end
      end
      default: begin
      end
    endcase

    if (!fire) begin
      win_nxt       = win_r;
      thr_nxt       = thr_r;
      mode_nxt      = mode_r;
      rtt_nxt       = rtt_r;
      smp_pend_nxt  = smp_pend_r;
      smp_num_nxt   = smp_num_r;
      smp_start_nxt = smp_start_r;
      acked_nxt     = acked_r;
      sent_nxt      = sent_r;
      dup_nxt       = dup_r;
      ack_time_nxt  = ack_time_r;
      send_time_nxt = send_time_r;
      grow_time_nxt = grow_time_r;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_THR: begin
          init_thr_nxt = cfg_data[WIN_W-1:0];
          thr_nxt      = cfg_data[WIN_W-1:0];
        end
        CFG_INIT_WIN: begin
          init_win_nxt = cfg_data[WIN_W-1:0];
          win_nxt      = clamp_win({1'b0, cfg_data[WIN_W-1:0]});
        end
        CFG_INIT_RTT: begin
          init_rtt_nxt = cfg_data[RTT_W-1:0];
          rtt_nxt      = cfg_data[RTT_W-1:0];
        end
        CFG_DUP_LIMIT: dup_lim_nxt  = cfg_data[DUP_W-1:0];
        CFG_ACK_TO:    ack_to_nxt   = cfg_data[RTT_W-1:0];
        CFG_CRASH_TO:  crash_to_nxt = cfg_data[CRASH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res.congestion_window = win_nxt;
  assign res.slow_threshold    = thr_nxt;
  assign res.in_avoidance      = mode_nxt;
  assign res.rtt_estimate_ms   = rtt_nxt;
  assign res.highest_acked     = acked_nxt;
  assign res.highest_sent      = sent_nxt;
  assign res.rewind            = rewind;
  assign res.peer_crashed      = crashed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_thr_r  <= 11'd64;
      init_win_r  <= 11'd1;
      init_rtt_r  <= 16'd200;
      dup_lim_r   <= 4'd3;
      ack_to_r    <= 16'd1000;
      crash_to_r  <= 20'd10000;
      win_r       <= clamp_win(12'd1);
      thr_r       <= 11'd64;
      mode_r      <= 1'b0;
      rtt_r       <= 16'd200;
      smp_pend_r  <= 1'b0;
      smp_num_r   <= '0;
      smp_start_r <= '0;
      acked_r     <= '0;
      sent_r      <= '0;
      dup_r       <= '0;
      ack_time_r  <= '0;
      send_time_r <= '0;
      grow_time_r <= '0;
    end else begin
      init_thr_r  <= init_thr_nxt;
      init_win_r  <= init_win_nxt;
      init_rtt_r  <= init_rtt_nxt;
      dup_lim_r   <= dup_lim_nxt;
      ack_to_r    <= ack_to_nxt;
      crash_to_r  <= crash_to_nxt;
      win_r       <= win_nxt;
      thr_r       <= thr_nxt;
      mode_r      <= mode_nxt;
      rtt_r       <= rtt_nxt;
      smp_pend_r  <= smp_pend_nxt;
      smp_num_r   <= smp_num_nxt;
      smp_start_r <= smp_start_nxt;
      acked_r     <= acked_nxt;
      sent_r      <= sent_nxt;
      dup_r       <= dup_nxt;
      ack_time_r  <= ack_time_nxt;
      send_time_r <= send_time_nxt;
      grow_time_r <= grow_time_nxt;
    end
  end

endmodule

>>> design/cwc_out_stage.sv
`timescale 1ns / 1ps
// cwc_out_stage: result register toward the output channel
// depends on cwc_pkg

module cwc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_take,
  input  cwc_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output cwc_pkg::result_t out_res
);
  import cwc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign item_take = item_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (item_take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res;
    end
  end

endmodule

>>> design/congestion_window_controller.sv
`timescale 1ns / 1ps
// congestion_window_controller: top level of the sender congestion window block
// depends on cwc_pkg, cwc_in_stage, cwc_update, cwc_out_stage
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | cmd, packet_number, now_ms, sample_this_send
//   out_    | output    | out_valid / out_ready| window, threshold, mode, rtt, acked, sent, flags
//   cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// a request waits in the input register until the result register takes it; its result is
// then offered from the result register; one request per cycle while out_ready is high
// the state update is a single pass of compares and adds between the two registers
// reset is synchronous and active low; it loads the default configuration and state
// when out_ready is low the result register holds and the input register fills,
// after which in_ready drops

module congestion_window_controller #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [cwc_pkg::PKT_W-1:0]           in_packet_number,
  input  logic [cwc_pkg::TIME_W-1:0]          in_now_ms,
  input  logic                                in_sample_this_send,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cwc_pkg::WIN_W-1:0]           out_congestion_window,
  output logic [cwc_pkg::WIN_W-1:0]           out_slow_threshold,
  output logic                                out_in_avoidance,
  output logic [cwc_pkg::RTT_W-1:0]           out_rtt_estimate_ms,
  output logic [cwc_pkg::PKT_W-1:0]           out_highest_acked,
  output logic [cwc_pkg::PKT_W-1:0]           out_highest_sent,
  output logic                                out_rewind,
  output logic                                out_peer_crashed,
  input  logic                                cfg_we,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cwc_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, item_take;

  assign in_item.cmd              = in_cmd;
  assign in_item.packet_number    = in_packet_number;
  assign in_item.now_ms           = in_now_ms;
  assign in_item.sample_this_send = in_sample_this_send;

  cwc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  cwc_update #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (item_take),
    .item      (item),
    .res       (res)
  );

  cwc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_take  (item_take),
    .res        (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_congestion_window = out_res.congestion_window;
  assign out_slow_threshold    = out_res.slow_threshold;
  assign out_in_avoidance      = out_res.in_avoidance;
  assign out_rtt_estimate_ms   = out_res.rtt_estimate_ms;
  assign out_highest_acked     = out_res.highest_acked;
  assign out_highest_sent      = out_res.highest_sent;
  assign out_rewind            = out_res.rewind;
  assign out_peer_crashed      = out_res.peer_crashed;

endmodule

>>> design/cwc_checker.sv
`timescale 1ns / 1ps
// cwc_port_assert: port-level assertions for the congestion window controller
// depends on cwc_pkg; bound to congestion_window_controller below

module cwc_port_assert #(
  parameter int WINDOW_MAX = 1024
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cwc_pkg::WIN_W-1:0]      out_congestion_window,
  input logic [cwc_pkg::WIN_W-1:0]      out_slow_threshold,
  input logic [cwc_pkg::PKT_W-1:0]      out_highest_acked,
  input logic [cwc_pkg::PKT_W-1:0]      out_highest_sent,
  input logic                           out_rewind,
  input logic                           out_peer_crashed
);
  import cwc_pkg::*;

  localparam int CAP_INT = (WINDOW_MAX < 2047) ? WINDOW_MAX : 2047;
  localparam logic [WIN_W-1:0] CAP = WIN_W'(CAP_INT);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_congestion_window)
      && $stable(out_highest_sent) && $stable(out_slow_threshold))
    else $error("result changed while stalled");

  // window always within its clamp range
  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_congestion_window != '0) && (out_congestion_window <= CAP))
    else $error("window out of range");

  // a rewind restarts sending right after the highest acked packet
  a_rewind_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rewind |-> out_highest_sent == out_highest_acked)
    else $error("rewind without sent number at acked number");

  // crash detection never rewinds in the same request
  a_crash_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_peer_crashed |-> !out_rewind)
    else $error("crash and rewind together");

endmodule

bind congestion_window_controller cwc_port_assert #(.WINDOW_MAX(WINDOW_MAX)) u_cwc_port_assert (.*);
